/* rtl/core/hex_string_array_encoder_top_macros.svh */
// Assertion macros for the hex string array encoder.
// Used by the RTL files under rtl/core; expects clk_i and rst_ni in scope.
`ifndef HEX_STRING_ARRAY_ENCODER_TOP_MACROS_SVH
`define HEX_STRING_ARRAY_ENCODER_TOP_MACROS_SVH

// property must hold at every clock edge outside reset
`define HSAE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define HSAE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSAE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/hsae_pkg.sv */
// Shared types, constants and helper functions of the hex string array encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package hsae_pkg;

  // operation codes of an input word
  localparam logic [1:0] OpData     = 2'd0;
  localparam logic [1:0] OpAnnounce = 2'd1;
  localparam logic [1:0] OpClose    = 2'd2;
  localparam logic [1:0] OpStart    = 2'd3;

  // command kinds passed from front to back
  localparam logic [1:0] CmdData  = 2'd0;
  localparam logic [1:0] CmdClose = 2'd1;
  localparam logic [1:0] CmdStart = 2'd2;

  // configuration register indexes
  localparam logic CfgWrapColumn  = 1'b0;
  localparam logic CfgStringLimit = 1'b1;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [6:0]  WrapColumnReset  = 7'd70;
  localparam logic [15:0] StringLimitReset = 16'd65528;
  localparam logic [6:0]  ColumnMax        = 7'd127;
  localparam logic [31:0] CountMax         = 32'hFFFF_FFFF;
  localparam logic [6:0]  StartColumn      = 7'd8;

  localparam logic [6:0] CharLt   = 7'h3C;
  localparam logic [6:0] CharGt   = 7'h3E;
  localparam logic [6:0] CharNl   = 7'h0A;
  localparam logic [6:0] CharZero = 7'h30;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [31:0] segment_length;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last;
  } out_item_t;

  // one queued command: what the back end has to spell out
  typedef struct packed {
    logic [1:0] kind;
    logic       lt;    // data: open a string first
    logic       nl;    // newline after the byte
    logic [7:0] data;
  } cmd_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (7'h30 + {3'd0, nib}) : (7'h37 + {3'd0, nib});
  endfunction

  function automatic logic [6:0] open_char(input logic [2:0] idx);
    logic [6:0] c;
    case (idx)
      3'd0:    c = 7'h2F; // '/'
      3'd1:    c = 7'h73; // 's'
      3'd2:    c = 7'h66; // 'f'
      3'd3:    c = 7'h6E; // 'n'
      3'd4:    c = 7'h74; // 't'
      3'd5:    c = 7'h73; // 's'
      3'd6:    c = 7'h5B; // '['
      3'd7:    c = CharLt;
      default: c = CharLt;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] col_add(input logic [6:0] col, input logic [1:0] n);
    logic [7:0] s;
    s = {1'b0, col} + {6'd0, n};
    return s[7] ? ColumnMax : s[6:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/hex_string_array_encoder_top.sv */
// Hex string array encoder: turns bytes into the text of a PostScript array of hex strings.
//
// Input queue side: drive in_i and raise push; the word is taken on an edge where full
// is low. Operations: data byte, segment announce, close string, start array.
// Output queue side: while empty is low, out_o holds the oldest character; raising pop
// takes it. last marks the final character caused by one input word.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 wrap column,
// 1 string limit); write only while the block is idle.
// Flow: the first character of a word passes the command queue head register, then the
// output register, before it is on out_o. The front end takes one word per cycle while
// full is low into a command queue (QueueDepth entries); the back end emits one character
// per cycle while pop keeps up, so a data byte spells out 2 to 4 characters, a close 3 to
// 4, a start 8; announces that force nothing and closes of no string emit nothing.
// A stall on pop holds the output register; the queue keeps taking words until full.
// Reset: no string open, byte count and column zero, registers at 70 and 65528,
// both queues empty.
`default_nettype none

module hex_string_array_encoder_top
  import hsae_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_i,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_cmd_in, q_cmd_out;

  hsae_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd_in)
  );

  hsae_cmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  hsae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd_out),
    .cmd_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* rtl/core/hsae_front.sv */
// Front end: takes input words, keeps string/column state, issues commands.
// Depends on hsae_pkg and the assertion macro header.
`default_nettype none
`include "hex_string_array_encoder_top_macros.svh"

module hsae_front
  import hsae_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output cmd_t             q_cmd_o
);

  logic [6:0]  wrap_q;
  logic [15:0] limit_q;
  logic        open_q, open_d;
  logic [31:0] bytes_q, bytes_d;
  logic [6:0]  col_q, col_d;

  logic        accept;
  logic [6:0]  col_a, col_b, col_c;
  logic [31:0] cnt_a;
  logic        nl_data, nl_close, do_close;
  logic [32:0] sum;

  assign full   = q_full_i;
  assign accept = push && !full;

  // data path: optional '<', then two digits
  assign col_a   = open_q ? col_q : col_add(col_q, 2'd1);
  assign cnt_a   = open_q ? bytes_q : '0;
  assign col_b   = col_add(col_a, 2'd2);
  assign nl_data = col_b > wrap_q;

  // close path: dummy byte into an open string, then '>'
  assign col_c    = col_add(col_q, 2'd2);
  assign nl_close = col_c > wrap_q;

  assign sum      = {1'b0, bytes_q} + {1'b0, in_i.segment_length};
  assign do_close = (in_i.operation == OpClose) ||
                    ((in_i.operation == OpAnnounce) && (sum > {17'd0, limit_q}));

  always_comb begin
    open_d   = open_q;
    bytes_d  = bytes_q;
    col_d    = col_q;
    q_push_o = 1'b0;
    q_cmd_o  = '{kind: CmdData, lt: !open_q, nl: nl_data, data: in_i.data_byte};
    if (accept) begin
      case (in_i.operation)
        OpData: begin
          q_push_o = 1'b1;
          open_d   = 1'b1;
          bytes_d  = (cnt_a == CountMax) ? cnt_a : cnt_a + 32'd1;
          col_d    = nl_data ? '0 : col_b;
        end
        OpStart: begin
          q_push_o     = 1'b1;
          q_cmd_o.kind = CmdStart;
          open_d       = 1'b1;
          bytes_d      = '0;
          col_d        = StartColumn;
        end
        default: begin
          if (do_close) begin
            open_d = 1'b0;
            if (open_q) begin
              q_push_o     = 1'b1;
              q_cmd_o.kind = CmdClose;
              q_cmd_o.nl   = nl_close;
              bytes_d      = 32'd1;
              col_d        = col_add(nl_close ? '0 : col_c, 2'd1);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q  <= WrapColumnReset;
      limit_q <= StringLimitReset;
      open_q  <= 1'b0;
      bytes_q <= '0;
      col_q   <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgWrapColumn) begin
        wrap_q <= cfg_wdata_i[6:0];
      end
      if (cfg_we_i && cfg_idx_i == CfgStringLimit) begin
        limit_q <= cfg_wdata_i;
      end
      open_q  <= open_d;
      bytes_q <= bytes_d;
      col_q   <= col_d;
    end
  end

  `HSAE_ASSERT_NEXT(a_start_opens, accept && in_i.operation == OpStart, open_q && col_q == StartColumn && bytes_q == '0, "start did not open a string")
  `HSAE_ASSERT_IMP(a_cmd_needs_accept, q_push_o, accept, "command issued without an accepted word")

endmodule

`default_nettype wire

/* rtl/core/hsae_cmd_queue.sv */
// Short command queue between front and back end.
// Depends on hsae_pkg and the assertion macro header.
`default_nettype none
`include "hex_string_array_encoder_top_macros.svh"

module hsae_cmd_queue
  import hsae_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  cmd_t            head_q;
  logic [PtrW-1:0] wr_q, rd_q, rd_d;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign rd_d    = pop_i ? ptr_inc(rd_q) : rd_q;
  assign cmd_o   = head_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
    // head after this edge; a word pushed into an emptying queue bypasses the array
    head_q <= (push_i && wr_q == rd_d) ? cmd_i : mem_q[rd_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      rd_q <= rd_d;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `HSAE_ASSERT(a_cnt_range, cnt_q <= CntW'(Depth), "queue count beyond depth")
  `HSAE_ASSERT_IMP(a_no_underflow, pop_i, cnt_q != '0, "pop from empty command queue")
  `HSAE_ASSERT_IMP(a_no_overflow, push_i && !pop_i, cnt_q != CntW'(Depth), "push into full queue")

endmodule

`default_nettype wire

/* rtl/core/hsae_back.sv */
// Back end: spells commands into the output register, one char per cycle unless pop stalls.
// Depends on hsae_pkg and the assertion macro header.
`default_nettype none
`include "hex_string_array_encoder_top_macros.svh"

module hsae_back
  import hsae_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      empty,
  input  wire logic pop,
  output out_item_t out_o
);

  logic [2:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_q;

  logic       adv;
  logic [1:0] pos;
  logic [6:0] chr;
  logic       is_last;

  assign adv = cmd_valid_i && (!out_valid_q || pop);

  // character at the current step of the head command
  always_comb begin
    pos     = idx_q[1:0];
    chr     = CharZero;
    is_last = 1'b1;
    case (cmd_i.kind)
      CmdData: begin
        pos = cmd_i.lt ? idx_q[1:0] : idx_q[1:0] + 2'd1;
        case (pos)
          2'd0:    chr = CharLt;
          2'd1:    chr = hex_char(cmd_i.data[7:4]);
          2'd2:    chr = hex_char(cmd_i.data[3:0]);
          default: chr = CharNl;
        endcase
        is_last = pos == (cmd_i.nl ? 2'd3 : 2'd2);
      end
      CmdClose: begin
        case (pos)
          2'd0, 2'd1: chr = CharZero;
          2'd2:       chr = cmd_i.nl ? CharNl : CharGt;
          default:    chr = CharGt;
        endcase
        is_last = pos == (cmd_i.nl ? 2'd3 : 2'd2);
      end
      CmdStart: begin
        chr     = open_char(idx_q);
        is_last = idx_q == 3'd7;
      end
      default: begin
        chr     = CharZero;
        is_last = 1'b1;
      end
    endcase
  end

  assign cmd_pop_o = adv && is_last;
  assign empty     = !out_valid_q;
  assign out_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= '{out_char: chr, last: is_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        idx_q <= is_last ? '0 : idx_q + 3'd1;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `HSAE_ASSERT_IMP(a_idx_needs_cmd, idx_q != '0, cmd_valid_i, "mid-command with no command queued")
  `HSAE_ASSERT_NEXT(a_adv_fills, adv, out_valid_q, "output register not loaded")

endmodule

`default_nettype wire

/* tb/hex_string_array_encoder_top_tb.sv */
// Self-checking testbench for hex_string_array_encoder_top.
// Drives words through the push/full queue port, predicts every character and
// checks the pop/empty side against it; needs only hsae_pkg and the RTL.
`default_nettype none

module hex_string_array_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsae_pkg::*;

  localparam int unsigned StallLimit   = 2000; // cycles with no word moving on either side
  localparam int unsigned SettleCycles = 20;   // lets silent words drain before a cfg write
  localparam int unsigned DrainCycles  = 30;
  localparam int unsigned ReportMax    = 10;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  data;
    logic [31:0] len;
    bit          typed;
    string       text;
  } dir_row_t;

  typedef struct {
    int unsigned wrap;
    int unsigned limit;
    int unsigned send_idle;
    int unsigned recv_stall;
    int unsigned words;
  } phase_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  in_item_t    in_word   = '0;
  logic        empty;
  logic        pop       = 1'b0;
  out_item_t   out_word;
  logic        cfg_we    = 1'b0;
  logic        cfg_idx   = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // encoder shadow state
  bit [6:0]  wrap_col;
  bit [15:0] str_limit;
  bit        str_open;
  bit [31:0] byte_count;
  bit [6:0]  column;

  logic [6:0]  chars[$];  // characters of the word being encoded
  out_item_t   char_q[$]; // characters still owed by the block, oldest first
  int unsigned errors      = 0;
  int unsigned recv_stall  = 0;
  int unsigned idle_cycles = 0;

  hex_string_array_encoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void col_bump(input int unsigned n);
    int unsigned s;
    s = column + n;
    column = (s > ColumnMax) ? ColumnMax : s[6:0];
  endfunction

  function automatic logic [6:0] nibble_char(input logic [3:0] n);
    string digits;
    byte   c;
    digits = "0123456789ABCDEF";
    c = digits.getc(n);
    return c[6:0];
  endfunction

  function automatic void encode_byte(input logic [7:0] b);
    if (!str_open) begin
      chars.push_back(CharLt);
      byte_count = '0;
      col_bump(1);
      str_open = 1'b1;
    end
    chars.push_back(nibble_char(b[7:4]));
    chars.push_back(nibble_char(b[3:0]));
    if (byte_count != CountMax) byte_count++;
    col_bump(2);
    if (column > wrap_col) begin
      chars.push_back(CharNl);
      column = '0;
    end
  endfunction

  // dummy 00 byte then '>'; leaves the count at one
  function automatic void close_string();
    if (str_open) begin
      byte_count = '0;
      encode_byte(8'h00);
      chars.push_back(CharGt);
      col_bump(1);
    end
    str_open = 1'b0;
  endfunction

  function automatic void encode(input in_item_t w);
    string opening;
    byte   c;
    opening = "/sfnts[<";
    chars.delete();
    case (w.operation)
      OpData: encode_byte(w.data_byte);
      OpAnnounce: begin
        // 33-bit sum, no wrap
        if ({1'b0, byte_count} + {1'b0, w.segment_length} > {17'd0, str_limit})
          close_string();
      end
      OpClose: close_string();
      OpStart: begin
        for (int i = 0; i < 8; i++) begin
          c = opening.getc(i);
          chars.push_back(c[6:0]);
        end
        str_open = 1'b1;
        byte_count = '0;
        column = StartColumn;
      end
    endcase
  endfunction

  function automatic void queue_chars();
    out_item_t e;
    foreach (chars[i]) begin
      e.out_char = chars[i];
      e.last = (i == chars.size() - 1);
      char_q.push_back(e);
    end
  endfunction

  function automatic void note_mismatch(input string what, input logic [6:0] want,
                                        input logic [6:0] got);
    errors++;
    if (errors <= ReportMax)
      $display("%0t ns: %s: expected %02h, got %02h", $time, what, want, got);
  endfunction

  function automatic in_item_t random_word();
    in_item_t w;
    int unsigned r;
    longint d;
    w.data_byte = $urandom_range(0, 255);
    w.segment_length = $urandom;
    r = $urandom_range(0, 99);
    if (r < 58) begin
      w.operation = OpData;
    end else if (r < 74) begin
      w.operation = OpAnnounce;
      case ($urandom_range(0, 3))
        0: ; // full range
        1: w.segment_length = $urandom_range(0, 40);
        2: begin
          // land on either side of the limit test
          d = longint'(str_limit) - longint'(byte_count) + longint'($urandom_range(0, 2)) - 1;
          w.segment_length = (d < 0) ? 32'd0 : d[31:0];
        end
        default: w.segment_length = 32'hFFFF_FFFF;
      endcase
    end else if (r < 90) begin
      w.operation = OpClose;
    end else begin
      w.operation = OpStart;
    end
    return w;
  endfunction

  // word is taken at the first edge with push high and full low
  task automatic send_word(input in_item_t w, input bit typed = 1'b0, input string text = "");
    byte c;
    push <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (full);
    encode(w);
    if (typed) begin
      chars.delete();
      for (int i = 0; i < text.len(); i++) begin
        c = text.getc(i);
        chars.push_back(c[6:0]);
      end
    end
    queue_chars();
  endtask

  task automatic sender_gap(input int unsigned pct);
    while ($urandom_range(0, 99) < pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic hold_until_drained();
    while (char_q.size() != 0) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic settle_and_configure(input logic [6:0] w, input logic [15:0] l);
    push <= 1'b0;
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CfgWrapColumn;
    cfg_wdata <= {9'd0, w};
    @(posedge clk_i);
    cfg_idx <= CfgStringLimit;
    cfg_wdata <= l;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    wrap_col = w;
    str_limit = l;
  endtask

  // result side: check the word taken at this edge, then pick next pop
  always @(posedge clk_i) begin
    out_item_t want;
    if (pop && !empty) begin
      if (char_q.size() == 0) begin
        note_mismatch("char with none pending", 7'd0, out_word.out_char);
      end else begin
        want = char_q.pop_front();
        if (want.out_char !== out_word.out_char)
          note_mismatch("out_char", want.out_char, out_word.out_char);
        if (want.last !== out_word.last)
          note_mismatch("last", {6'd0, want.last}, {6'd0, out_word.last});
      end
    end
    pop <= rst_ni && ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t rows[$];
    phase_t   phases[$];
    in_item_t w;

    wrap_col   = WrapColumnReset;
    str_limit  = StringLimitReset;
    str_open   = 1'b0;
    byte_count = '0;
    column     = '0;

    // directed words at reset settings (wrap 70, limit 65528)
    rows = '{
      '{OpClose,    8'h00, 32'h0000_0000, 1'b1, ""},         // close, nothing open
      '{OpAnnounce, 8'h00, 32'hFFFF_FFFF, 1'b1, ""},         // announce fires, nothing open
      '{OpData,     8'h00, 32'hFFFF_FFFF, 1'b1, "<00"},
      '{OpData,     8'hFF, 32'h0000_0000, 1'b1, "FF"},
      '{OpData,     8'hA5, 32'h0000_0000, 1'b0, ""},
      '{OpData,     8'h5A, 32'h0000_0000, 1'b0, ""},
      '{OpAnnounce, 8'hFF, 32'h0000_0000, 1'b1, ""},
      '{OpAnnounce, 8'h00, 32'd65524,     1'b1, ""},         // sum equals limit
      '{OpAnnounce, 8'h00, 32'd65525,     1'b1, "00>"},      // one past the limit
      '{OpClose,    8'h00, 32'h0000_0000, 1'b1, ""},
      '{OpAnnounce, 8'h00, 32'd65527,     1'b1, ""},         // count of one after close
      '{OpAnnounce, 8'h00, 32'd65528,     1'b1, ""},
      '{OpStart,    8'hFF, 32'hFFFF_FFFF, 1'b1, "/sfnts[<"},
      '{OpData,     8'h3C, 32'h0000_0000, 1'b0, ""},
      '{OpStart,    8'h00, 32'h0000_0000, 1'b1, "/sfnts[<"}, // start while open
      '{OpData,     8'h7E, 32'h1234_5678, 1'b0, ""},
      '{OpClose,    8'hFF, 32'hFFFF_FFFF, 1'b0, ""},
      '{OpData,     8'h80, 32'h0000_0000, 1'b0, ""},
      '{OpData,     8'h01, 32'h0000_0000, 1'b0, ""},
      '{OpAnnounce, 8'h00, 32'hFFFF_FFFF, 1'b0, ""},
      '{OpData,     8'hC3, 32'h0000_0000, 1'b0, ""},
      '{OpClose,    8'h00, 32'h0000_0000, 1'b0, ""}
    };

    phases = '{
      '{0,   1,     0,  0,  58},  // newline after every byte
      '{127, 65535, 78, 0,  58},  // column saturates, never wraps
      '{1,   0,     0,  78, 58},
      '{126, 16,    14, 14, 58},
      '{$urandom_range(1, 127), $urandom_range(1, 65535), 0, 0, 58},
      '{$urandom_range(1, 127), $urandom_range(1, 300), 78, 78, 58}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      w.operation      = rows[i].op;
      w.data_byte      = rows[i].data;
      w.segment_length = rows[i].len;
      send_word(w, rows[i].typed, rows[i].text);
    end

    foreach (phases[p]) begin
      settle_and_configure(phases[p].wrap[6:0], phases[p].limit[15:0]);
      recv_stall = phases[p].recv_stall;
      for (int n = 0; n < phases[p].words; n++) begin
        if (n == phases[p].words / 2) hold_until_drained();
        sender_gap(phases[p].send_idle);
        send_word(random_word());
      end
    end

    push <= 1'b0;
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && char_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/hsae_pkg.sv
rtl/core/hsae_front.sv
rtl/core/hsae_cmd_queue.sv
rtl/core/hsae_back.sv
rtl/core/hex_string_array_encoder_top.sv
tb/hex_string_array_encoder_top_tb.sv
